// File: hdl/tidrt_pkg.sv
`timescale 1ns / 1ps

package tidrt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ID_W        = 5;
  // wide enough for both a mapped ID and TABLE_DEPTH itself
  localparam int CMP_W       = (ID_W > IDX_W + 1) ? ID_W : IDX_W + 1;
  localparam int LIFE_W      = 16;
  localparam int TIME_W      = 32;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(10);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RESOLVE = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ALLOC    = 3'd0,
    ST_FULL     = 3'd1,
    ST_RESOLVED = 3'd2,
    ST_TICK     = 3'd3,
    ST_BAD      = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] orig_id;
    logic [31:0] ip;
    logic [15:0] port;
  } entry_data_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] expiry;
  } entry_stat_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [15:0]     orig_id;
    logic [31:0]     client_ip;
    logic [15:0]     client_port;
    logic [ID_W-1:0] mapped_id;
  } in_item_t;

  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] new_id;
    logic [15:0]     found_orig_id;
    logic [31:0]     found_ip;
    logic [15:0]     found_port;
  } res_item_t;

endpackage

// File: hdl/tidrt_ram.sv
`timescale 1ns / 1ps

module tidrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hdl/tidrt_engine.sv
`timescale 1ns / 1ps

module tidrt_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tidrt_pkg::in_item_t                 in_item_i,
  input  logic [tidrt_pkg::TIME_W-1:0]        now_i,
  input  logic [tidrt_pkg::LIFE_W-1:0]        lifetime_i,
  output logic                                tick_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tidrt_pkg::res_item_t                out_item_o
);

  import tidrt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RES_RD,
    S_RESULT
  } state_e;

  state_e            state_q;
  in_item_t          item_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [TABLE_DEPTH-1:0] written_q;
  res_item_t         res_q;
  res_item_t         out_q;
  logic              out_valid_q;
  logic              tick_q;

  entry_data_t       data_rdata, data_wdata;
  entry_stat_t       stat_rdata, stat_wdata;
  logic              data_we, stat_we;
  logic [IDX_W-1:0]  raddr;

  logic              accept;
  logic              slot_free;
  logic              map_ok;
  logic [CMP_W-1:0]  mid_wide, mid_m1, id_wide;
  logic [IDX_W-1:0]  mid_idx;
  logic [TIME_W-1:0] expiry_new;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE);

  assign mid_wide = CMP_W'(in_item_i.mapped_id);
  assign mid_m1   = mid_wide - CMP_W'(1);
  assign mid_idx  = mid_m1[IDX_W-1:0];
  assign map_ok   = (mid_wide != '0) && (mid_wide <= CMP_W'(TABLE_DEPTH));
  assign id_wide  = CMP_W'(rd_idx_q) + CMP_W'(1);

  // never-written entries read as reset contents: free, zero payload
  assign slot_free = !written_q[rd_idx_q] || stat_rdata.done ||
                     ((stat_rdata.expiry != '0) && (stat_rdata.expiry <= now_i));
  assign expiry_new = now_i + TIME_W'(lifetime_i);

  always_comb begin
    raddr      = rd_idx_q + IDX_W'(1);
    data_we    = 1'b0;
    stat_we    = 1'b0;
    data_wdata = '{orig_id: item_q.orig_id, ip: item_q.client_ip,
                   port: item_q.client_port};
    stat_wdata = '{done: 1'b0, expiry: expiry_new};
    unique case (state_q)
      S_IDLE: begin
        raddr = (in_item_i.cmd == CMD_RESOLVE) ? mid_idx : '0;
      end
      S_SCAN: begin
        data_we = slot_free;
        stat_we = slot_free;
      end
      S_RES_RD: begin
        // read-modify-write: set done, keep expiry
        stat_we    = written_q[rd_idx_q];
        stat_wdata = '{done: 1'b1, expiry: stat_rdata.expiry};
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  tidrt_ram #(
    .WIDTH($bits(entry_data_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (data_we),
    .waddr_i(rd_idx_q),
    .wdata_i(data_wdata),
    .raddr_i(raddr),
    .rdata_o(data_rdata)
  );

  tidrt_ram #(
    .WIDTH($bits(entry_stat_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_stat_ram (
    .clk_i  (clk_i),
    .we_i   (stat_we),
    .waddr_i(rd_idx_q),
    .wdata_i(stat_wdata),
    .raddr_i(raddr),
    .rdata_o(stat_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      rd_idx_q    <= '0;
      written_q   <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      tick_q      <= 1'b0;
    end else begin
      tick_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            item_q <= in_item_i;
            res_q  <= '{status: ST_BAD, default: '0};
            priority if (in_item_i.cmd == CMD_ALLOC) begin
              rd_idx_q <= '0;
              state_q  <= S_SCAN;
            end else if (in_item_i.cmd == CMD_RESOLVE && map_ok) begin
              rd_idx_q <= mid_idx;
              state_q  <= S_RES_RD;
            end else if (in_item_i.cmd == CMD_TICK) begin
              tick_q       <= 1'b1;
              res_q.status <= ST_TICK;
              state_q      <= S_RESULT;
            end else begin
              state_q <= S_RESULT;
            end
          end
        end
        S_SCAN: begin
          priority if (slot_free) begin
            written_q[rd_idx_q] <= 1'b1;
            res_q.status        <= ST_ALLOC;
            res_q.new_id        <= id_wide[ID_W-1:0];
            state_q             <= S_RESULT;
          end else if (rd_idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
            res_q.status <= ST_FULL;
            state_q      <= S_RESULT;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end
        S_RES_RD: begin
          res_q.status <= ST_RESOLVED;
          if (written_q[rd_idx_q]) begin
            res_q.found_orig_id <= data_rdata.orig_id;
            res_q.found_ip      <= data_rdata.ip;
            res_q.found_port    <= data_rdata.port;
          end
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign tick_o      = tick_q;

endmodule

// File: hdl/transaction_id_remap_table_top.sv
`timescale 1ns / 1ps
// Flow: an allocate scans from entry 0 to the first free entry k (0..15), or to the last
//   entry of a full table; a resolve reads its entry; tick and bad commands need no read.
// Throughput: one transaction at a time, one table entry examined per cycle by the scan
//   over the status memory.
// Reset: asynchronous, active low; all entries free, time counter 0, lifetime 10. The
//   entry memories are not cleared: a valid bit per entry stands in for their reset value.

module transaction_id_remap_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // lifetime register
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // orig_id[15:0], client_ip[47:16],
                                      // client_port[63:48], mapped_id[68:64], zero pad
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // new_id[4:0], found_orig_id[20:5],
                                      // found_ip[52:21], found_port[68:53], zero pad
  output logic [2:0]  m_axis_tuser    // status[2:0]
);

  import tidrt_pkg::*;

  logic [LIFE_W-1:0] lifetime_q;
  logic [TIME_W-1:0] now_q;
  logic              tick;
  in_item_t          in_item;
  res_item_t         res_item;

  // lifetime register and tick counter, advanced on each tick command (wraps mod 2^32)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= LIFETIME_RESET;
      now_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        lifetime_q <= cfg_wdata_i;
      end
      if (tick) begin
        now_q <= now_q + TIME_W'(1);
      end
    end
  end

  assign in_item.cmd         = s_axis_tuser;
  assign in_item.orig_id     = s_axis_tdata[15:0];
  assign in_item.client_ip   = s_axis_tdata[47:16];
  assign in_item.client_port = s_axis_tdata[63:48];
  assign in_item.mapped_id   = s_axis_tdata[68:64];

  tidrt_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .now_i      (now_q),
    .lifetime_i (lifetime_q),
    .tick_o     (tick),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_item_o (res_item)
  );

  assign m_axis_tuser = res_item.status;
  assign m_axis_tdata = {3'b000, res_item.found_port, res_item.found_ip,
                         res_item.found_orig_id, res_item.new_id};

endmodule

// File: verif/id_remap_checker.sv
`timescale 1ns / 1ps

module id_remap_checker
  import tidrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [71:0] req_data_i,
  input  logic [1:0]  req_user_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [71:0] rsp_data_i,
  input  logic [2:0]  rsp_user_i,
  output int          outstanding_o,
  output int          errors_o
);

  logic [LIFE_W-1:0] lifetime;
  logic [TIME_W-1:0] now_ticks;
  entry_data_t       slot_data   [TABLE_DEPTH];
  logic              slot_done   [TABLE_DEPTH];
  logic [TIME_W-1:0] slot_expiry [TABLE_DEPTH];
  res_item_t         expected_replies [$];
  int                errors;

  // Applies one request to the shadow table and returns the reply it must produce.
  function automatic res_item_t predict_remap(in_item_t req);
    res_item_t   r;
    logic        placed;
    int          k;
    r        = '0;
    r.status = ST_BAD;
    placed   = 1'b0;
    case (req.cmd)
      CMD_ALLOC: begin
        r.status = ST_FULL;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!placed && (slot_done[i] ||
              (slot_expiry[i] != '0 && slot_expiry[i] <= now_ticks))) begin
            placed               = 1'b1;
            slot_data[i].orig_id = req.orig_id;
            slot_data[i].ip      = req.client_ip;
            slot_data[i].port    = req.client_port;
            slot_done[i]         = 1'b0;
            slot_expiry[i]       = now_ticks + TIME_W'(lifetime);
            r.status             = ST_ALLOC;
            r.new_id             = ID_W'(i + 1);
          end
        end
      end
      CMD_RESOLVE: begin
        if (req.mapped_id >= 1 && req.mapped_id <= TABLE_DEPTH) begin
          k               = int'(req.mapped_id) - 1;
          r.found_orig_id = slot_data[k].orig_id;
          r.found_ip      = slot_data[k].ip;
          r.found_port    = slot_data[k].port;
          slot_done[k]    = 1'b1;
          r.status        = ST_RESOLVED;
        end
      end
      CMD_TICK: begin
        now_ticks = now_ticks + 1'b1;
        r.status  = ST_TICK;
      end
      default: r.status = ST_BAD;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    in_item_t  req;
    res_item_t got;
    res_item_t want;
    if (!rst_ni) begin
      lifetime  = LIFETIME_RESET;
      now_ticks = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_data[i]   = '0;
        slot_done[i]   = 1'b1;
        slot_expiry[i] = '0;
      end
      expected_replies.delete();
      errors = 0;
      outstanding_o <= 0;
      errors_o      <= 0;
    end else begin
      if (cfg_we_i) lifetime = cfg_wdata_i;

      // check the reply before queuing a new prediction
      if (rsp_valid_i && rsp_ready_i) begin
        got.status        = status_e'(rsp_user_i);
        got.new_id        = rsp_data_i[4:0];
        got.found_orig_id = rsp_data_i[20:5];
        got.found_ip      = rsp_data_i[52:21];
        got.found_port    = rsp_data_i[68:53];
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected reply, status %0d new_id %0d orig_id %h ip %h port %h",
                   $time, got.status, got.new_id, got.found_orig_id, got.found_ip,
                   got.found_port);
        end else begin
          want = expected_replies.pop_front();
          if (got.status != want.status || got.new_id != want.new_id ||
              got.found_orig_id != want.found_orig_id || got.found_ip != want.found_ip ||
              got.found_port != want.found_port) begin
            errors++;
            $display("%0t: reply mismatch, expected status %0d new_id %0d orig_id %h ip %h %s",
                     $time, want.status, want.new_id, want.found_orig_id, want.found_ip,
                     $sformatf("port %h", want.found_port));
            $display("%0t:                 actual status %0d new_id %0d orig_id %h ip %h port %h",
                     $time, got.status, got.new_id, got.found_orig_id, got.found_ip,
                     got.found_port);
          end
        end
      end

      if (req_valid_i && req_ready_i) begin
        req.cmd         = req_user_i;
        req.orig_id     = req_data_i[15:0];
        req.client_ip   = req_data_i[47:16];
        req.client_port = req_data_i[63:48];
        req.mapped_id   = req_data_i[68:64];
        expected_replies.push_back(predict_remap(req));
      end

      outstanding_o <= expected_replies.size();
      errors_o      <= errors;
    end
  end

endmodule

// File: verif/transaction_id_remap_table_top_tb.sv
`timescale 1ns / 1ps

module transaction_id_remap_table_top_tb;
  import tidrt_pkg::*;

  // cmd code the block does not define; must answer ST_BAD
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         PHASE_ITEMS  = 225;
  localparam int         HOLD_CYCLES  = 400;   // one long receiver stall
  localparam int         DRAIN_CYCLES = 40;    // extra wait after the last reply
  localparam int         IDLE_LIMIT   = 3000;  // cycles with no transaction at all

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [71:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [71:0] m_axis_tdata;
  wire  [2:0]  m_axis_tuser;

  int outstanding;
  int errors;
  bit hold_go = 1'b0;   // asks the receiver for its long stall

  always #5 clk_i = ~clk_i;

  transaction_id_remap_table_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  id_remap_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_data_i    (s_axis_tdata),
    .req_user_i    (s_axis_tuser),
    .rsp_valid_i   (m_axis_tvalid),
    .rsp_ready_i   (m_axis_tready),
    .rsp_data_i    (m_axis_tdata),
    .rsp_user_i    (m_axis_tuser),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  // Idle length: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Request with random payload; payload fields are driven even where ignored.
  function automatic in_item_t make_req(logic [1:0] cmd, logic [ID_W-1:0] mapped);
    in_item_t r;
    r.cmd         = cmd;
    r.orig_id     = 16'($urandom);
    r.client_ip   = $urandom;
    r.client_port = 16'($urandom);
    r.mapped_id   = mapped;
    return r;
  endfunction

  // Weighted mix; the rest of the percentage goes to the unused command.
  // Resolves mostly target real table IDs, one in ten takes any 5-bit value.
  function automatic in_item_t random_req(int alloc_w, int resolve_w, int tick_w);
    int              roll;
    logic [ID_W-1:0] mapped;
    roll   = $urandom_range(0, 99);
    mapped = ($urandom_range(0, 9) == 0) ? ID_W'($urandom)
                                         : ID_W'($urandom_range(1, TABLE_DEPTH));
    if (roll < alloc_w) return make_req(CMD_ALLOC, mapped);
    if (roll < alloc_w + resolve_w) return make_req(CMD_RESOLVE, mapped);
    if (roll < alloc_w + resolve_w + tick_w) return make_req(CMD_TICK, mapped);
    return make_req(CMD_UNUSED, mapped);
  endfunction

  // Offers one transaction after an optional gap and returns at the edge that takes it.
  // Valid stays up when the next transaction follows with no gap.
  task automatic send_req(in_item_t req, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, req.mapped_id, req.client_port, req.client_ip, req.orig_id};
    s_axis_tuser  <= req.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait for every predicted reply. The first edge is always
  // waited out so a transaction taken at the last edge is already counted.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_lifetime(logic [15:0] life);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= life;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One random phase under a fixed lifetime, written while the block is idle.
  task automatic run_phase(logic [15:0] life, int alloc_w, int resolve_w, int tick_w);
    wait_drained();
    write_lifetime(life);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // first stretch of each 90 goes back to back
      send_req(random_req(alloc_w, resolve_w, tick_w), (i % 90 < 15) ? 0 : idle_len());
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero lifetime at time 0: expiry lands on 0 and never times out. After a tick
    // the expiry equals the current time, so the entry is reusable at once.
    write_lifetime('0);
    send_req(make_req(CMD_ALLOC, '0), 0);
    send_req(make_req(CMD_TICK, '0), 0);
    send_req(make_req(CMD_ALLOC, '0), 0);
    send_req(make_req(CMD_ALLOC, '0), 1);
    wait_drained();
    write_lifetime(LIFETIME_RESET);

    // bad mapped IDs at both ends, the unused command, a never-written entry
    send_req(make_req(CMD_RESOLVE, '0), 0);
    send_req(make_req(CMD_RESOLVE, '1), 0);
    send_req('1, 2);
    send_req(make_req(CMD_RESOLVE, ID_W'(TABLE_DEPTH)), 0);

    // payload extremes, then a resolve of the expiry-0 entry and its repeat
    send_req('{cmd: CMD_ALLOC, orig_id: '1, client_ip: '1, client_port: '1,
               mapped_id: '1}, 0);
    send_req('{cmd: CMD_ALLOC, orig_id: '0, client_ip: '0, client_port: '0,
               mapped_id: '0}, 0);
    send_req(make_req(CMD_RESOLVE, ID_W'(1)), 0);
    send_req(make_req(CMD_RESOLVE, ID_W'(1)), 0);
    send_req(make_req(CMD_TICK, '0), 0);

    // fill the table until allocates report full
    for (int i = 0; i < 15; i++) send_req(make_req(CMD_ALLOC, '0), 0);

    // random phases over several lifetimes, extremes included
    run_phase(16'd1, 40, 30, 27);
    run_phase(16'd0, 45, 30, 22);
    hold_go = 1'b1;   // receiver stalls long while the sender keeps offering
    run_phase(16'hFFFF, 50, 37, 10);
    run_phase(16'($urandom_range(2, 40)), 45, 30, 22);
    run_phase(16'($urandom_range(1, 65535)), 45, 35, 17);
    run_phase(LIFETIME_RESET, 42, 33, 22);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Reply side backpressure: random gaps, ready runs of varied length, one long hold.
  initial begin
    bit held;
    int gap;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                             : $urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
hdl/tidrt_pkg.sv
hdl/tidrt_ram.sv
hdl/tidrt_engine.sv
hdl/transaction_id_remap_table_top.sv
verif/id_remap_checker.sv
verif/transaction_id_remap_table_top_tb.sv
